>>> rtl/bed_pkg.sv
// shared types and constants for the boolean entropy decoder
package bed_pkg;

    localparam int BUF_W      = 64;
    localparam int FILL_W     = $clog2(BUF_W + 1);
    localparam int OUT_FILL_W = 7;
    localparam int BYTE_W     = 8;
    localparam int MIN_FILL   = 15;

    localparam logic [BYTE_W-1:0] RANGE_RESET = 8'd255;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_DECODE  = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STARVED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

>>> rtl/bed_if.sv
// command and response channel interfaces of the boolean entropy decoder
interface bed_cmd_if;
    import bed_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] probability;

    modport source (output valid, output operation, output data_byte, output probability,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input probability,
                    output ready);
endinterface

interface bed_rsp_if;
    import bed_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  decoded_bit;
    logic [1:0]            status;
    logic [OUT_FILL_W-1:0] buffered_bits;

    modport source (output valid, output decoded_bit, output status, output buffered_bits,
                    input ready);
    modport sink   (input valid, input decoded_bit, input status, input buffered_bits,
                    output ready);
endinterface

>>> rtl/boolean_entropy_decoder_top.sv
// boolean entropy decoder top level: bit buffer, range coder and result register
//
//  channel  dir  transfer carries
//  cmd      in   operation, data_byte, probability
//  rsp      out  decoded_bit, status, buffered_bits
//
// one item per cycle sustained while rsp is ready; each item is held in the command register
// and then moves on to the response register
// the coder state is updated when an item leaves the command register, so each
// item sees the state left by the one before it
// reset clears the buffer, the fill count and sets the range to 255
// a stalled rsp holds its transfer; cmd takes one more item, then waits until rsp frees
module boolean_entropy_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    bed_cmd_if.sink       cmd,
    bed_rsp_if.source     rsp
);
    import bed_pkg::*;

    logic                  cmd_valid_reg;
    logic [1:0]            op_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [BYTE_W-1:0]     prob_reg;

    logic [BUF_W-1:0]      buf_reg;
    logic [BUF_W-1:0]      buf_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [BYTE_W-1:0]     range_reg;
    logic [BYTE_W-1:0]     range_next;

    logic                  rsp_valid_reg;
    logic                  bit_reg;
    logic                  bit_next;
    status_t               status_reg;
    status_t               status_next;
    logic [FILL_W-1:0]     rsp_fill_reg;

    logic                  rsp_free;
    logic                  advance;

    logic [BYTE_W-1:0]     range_m1;
    logic [2*BYTE_W-1:0]   product;
    logic [BYTE_W-1:0]     split;
    logic [FILL_W-1:0]     pos;
    logic [BYTE_W-1:0]     win;
    logic [BYTE_W-1:0]     win_new;
    logic [BYTE_W-1:0]     r_raw;
    logic [2:0]            shift;
    logic [FILL_W-1:0]     fill_dec;

    function automatic logic [BUF_W-1:0] low_mask(input logic [FILL_W-1:0] n);
        low_mask = ~({BUF_W{1'b1}} << n);
    endfunction

    function automatic logic [2:0] lead_zeros(input logic [BYTE_W-1:0] v);
        logic [2:0] cnt;
        cnt = 3'd0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (v[i])
            begin
                cnt = 3'(BYTE_W - 1 - i);
            end
        end
        lead_zeros = cnt;
    endfunction

    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign advance   = cmd_valid_reg && rsp_free;
    assign cmd.ready = !cmd_valid_reg || rsp_free;

    // decode datapath
    always_comb
    begin
        range_m1 = range_reg - 8'd1;
        product  = (2*BYTE_W)'(range_m1) * (2*BYTE_W)'(prob_reg);
        split    = product[2*BYTE_W-1:BYTE_W];
        pos      = fill_reg - FILL_W'(BYTE_W);
        win      = BYTE_W'(buf_reg >> pos);
        if (win > split)
        begin
            bit_next = 1'b1;
            win_new  = win - split - 8'd1;
            r_raw    = range_m1 - split;
        end
        else
        begin
            bit_next = 1'b0;
            win_new  = win;
            r_raw    = split + 8'd1;
        end
        shift    = lead_zeros(r_raw);
        fill_dec = fill_reg - FILL_W'(shift);
    end

    // state update per operation
    always_comb
    begin
        buf_next    = buf_reg;
        fill_next   = fill_reg;
        range_next  = range_reg;
        status_next = ST_OK;
        unique case (op_reg)
            OP_PUSH:
            begin
                if ((FILL_W + 1)'(fill_reg) + (FILL_W + 1)'(BYTE_W) > (FILL_W + 1)'(BUF_W))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    buf_next  = (buf_reg << BYTE_W) | BUF_W'(byte_reg);
                    fill_next = fill_reg + FILL_W'(BYTE_W);
                end
            end
            OP_DECODE:
            begin
                if (fill_reg < FILL_W'(MIN_FILL))
                begin
                    status_next = ST_STARVED;
                end
                else
                begin
                    buf_next   = ((buf_reg & low_mask(pos)) | (BUF_W'(win_new) << pos))
                                 & low_mask(fill_dec);
                    fill_next  = fill_dec;
                    range_next = r_raw << shift;
                end
            end
            OP_RESTART:
            begin
                buf_next   = '0;
                fill_next  = '0;
                range_next = RANGE_RESET;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            buf_reg       <= '0;
            fill_reg      <= '0;
            range_reg     <= RANGE_RESET;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= cmd_valid_reg;
            end
            if (advance)
            begin
                buf_reg   <= buf_next;
                fill_reg  <= fill_next;
                range_reg <= range_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg   <= cmd.operation;
            byte_reg <= cmd.data_byte;
            prob_reg <= cmd.probability;
        end
        if (advance)
        begin
            bit_reg      <= (op_reg == OP_DECODE && status_next == ST_OK) ? bit_next : 1'b0;
            status_reg   <= status_next;
            rsp_fill_reg <= fill_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.decoded_bit   = bit_reg;
    assign rsp.status        = status_reg;
    assign rsp.buffered_bits = OUT_FILL_W'(rsp_fill_reg);

endmodule

>>> rtl/bed_checker.sv
// port-level checks of the boolean entropy decoder and their bind
module bed_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_decoded_bit,
    input logic [1:0]                    rsp_status,
    input logic [bed_pkg::OUT_FILL_W-1:0] rsp_buffered_bits
);
    import bed_pkg::*;

    // nothing leaves while in reset
    a_no_rsp_in_reset: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // a stalled response holds its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_decoded_bit)
            && $stable(rsp_status) && $stable(rsp_buffered_bits))
        else $error("stalled response changed");

    // refused items never carry a decoded one
    a_refused_bit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> !rsp_decoded_bit)
        else $error("refused item with decoded bit set");

    // a full refusal only with no room for a byte
    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |->
            rsp_buffered_bits > OUT_FILL_W'(BUF_W - BYTE_W))
        else $error("push refused with room left");

    // a starved refusal only below the minimum fill
    a_starved_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_STARVED |-> rsp_buffered_bits < OUT_FILL_W'(MIN_FILL))
        else $error("decode refused with enough bits");

endmodule

bind boolean_entropy_decoder_top bed_checker u_bed_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_decoded_bit   (rsp.decoded_bit),
    .rsp_status        (rsp.status),
    .rsp_buffered_bits (rsp.buffered_bits)
);

>>> tb/testbench.sv
// testbench for boolean_entropy_decoder_top: scoreboard with its own coder model, random traffic
import bed_pkg::*;

localparam logic [1:0] OP_UNUSED = 2'd3;

typedef struct {
    logic                  decoded_bit;
    logic [1:0]            status;
    logic [OUT_FILL_W-1:0] buffered_bits;
} bool_result_t;

class decode_scoreboard;
    logic [BUF_W-1:0]  bit_store;
    int unsigned       fill;
    logic [BYTE_W-1:0] coder_range;
    bool_result_t      expected_q[$];
    int                errors;

    function new();
        bit_store   = '0;
        fill        = 0;
        coder_range = RANGE_RESET;
        errors      = 0;
    endfunction

    function logic [BUF_W-1:0] low_ones(int unsigned n);
        if (n >= BUF_W)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // advance the coder by one accepted command and queue its result
    function void note_command(logic [1:0] op, logic [7:0] data, logic [7:0] prob);
        bool_result_t      res;
        int unsigned       pos;
        int unsigned       shift;
        logic [7:0]        win;
        logic [7:0]        split;
        logic [7:0]        range_m1;
        logic [7:0]        next_range;
        logic [15:0]       product;
        res.decoded_bit = 1'b0;
        res.status      = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (fill + 8 > BUF_W)
                    res.status = ST_FULL;
                else
                begin
                    bit_store = {bit_store[BUF_W-9:0], data};
                    fill      = fill + 8;
                end
            end
            OP_DECODE:
            begin
                if (fill < MIN_FILL)
                    res.status = ST_STARVED;
                else
                begin
                    pos      = fill - 8;
                    win      = 8'(bit_store >> pos);
                    range_m1 = coder_range - 8'd1;
                    product  = 16'(range_m1) * 16'(prob);
                    split    = product[15:8];
                    if (win > split)
                    begin
                        res.decoded_bit = 1'b1;
                        win             = win - split - 8'd1;
                        next_range      = range_m1 - split;
                    end
                    else
                        next_range = split + 8'd1;
                    shift = 0;
                    while (next_range < 8'd128)
                    begin
                        next_range = next_range << 1;
                        shift++;
                    end
                    bit_store   = (bit_store & low_ones(pos)) | (64'(win) << pos);
                    fill        = fill - shift;
                    bit_store   = bit_store & low_ones(fill);
                    coder_range = next_range;
                end
            end
            OP_RESTART:
            begin
                bit_store   = '0;
                fill        = 0;
                coder_range = RANGE_RESET;
            end
            default:
            begin
            end
        endcase
        res.buffered_bits = OUT_FILL_W'(fill);
        expected_q.push_back(res);
    endfunction

    function void check_response(logic dec_bit, logic [1:0] status, logic [6:0] fill_out);
        bool_result_t exp_res;
        if (expected_q.size() == 0)
        begin
            $error("unexpected response transfer: decoded_bit %0d status %0d buffered_bits %0d",
                   dec_bit, status, fill_out);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (dec_bit !== exp_res.decoded_bit)
        begin
            $error("decoded_bit: expected %0d, got %0d", exp_res.decoded_bit, dec_bit);
            errors++;
        end
        if (status !== exp_res.status)
        begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            errors++;
        end
        if (fill_out !== exp_res.buffered_bits)
        begin
            $error("buffered_bits: expected %0d, got %0d", exp_res.buffered_bits, fill_out);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 120;
    localparam int RANDOM_ITEMS = 425;

    logic clk;
    logic rst_n;
    bit   no_idle;
    bit   hold_request;
    int   cycle_count;

    decode_scoreboard decoder_sb;

    bed_cmd_if cmd_bus();
    bed_rsp_if rsp_bus();

    boolean_entropy_decoder_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_command(input logic [1:0] op, input logic [7:0] data,
                                input logic [7:0] prob);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.operation   <= op;
        cmd_bus.data_byte   <= data;
        cmd_bus.probability <= prob;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        decoder_sb.note_command(op, data, prob);
    endtask

    function automatic logic [7:0] pick_probability();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // response side: random stalls plus one long hold-off on request
    initial
    begin : rsp_ready_drive
        int stall;
        stall = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = LONG_HOLD;
            end
            else if (stall == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall--;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    initial
    begin : rsp_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
                decoder_sb.check_response(rsp_bus.decoded_bit, rsp_bus.status,
                                          rsp_bus.buffered_bits);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("boolean_entropy_decoder_top test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         r;
        int         push_pct;
        logic [1:0] op;
        decoder_sb   = new();
        no_idle      = 1'b0;
        hold_request = 1'b0;
        rst_n               <= 1'b0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.operation   <= OP_PUSH;
        cmd_bus.data_byte   <= '0;
        cmd_bus.probability <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // starved decode, first bools, full buffer, unused code, zero stream tail
        send_command(OP_RESTART, 8'h00, 8'h00);
        send_command(OP_DECODE, 8'h00, 8'h80);
        send_command(OP_PUSH, 8'hFF, 8'h00);
        send_command(OP_PUSH, 8'h00, 8'h00);
        send_command(OP_DECODE, 8'h00, 8'hFF);
        send_command(OP_DECODE, 8'h00, 8'h00);
        send_command(OP_RESTART, 8'h00, 8'h00);
        for (int i = 0; i < 9; i++)
            send_command(OP_PUSH, 8'($urandom_range(0, 255)), 8'h00);
        send_command(OP_DECODE, 8'h00, 8'h80);
        send_command(OP_DECODE, 8'h00, 8'h01);
        send_command(OP_UNUSED, 8'hFF, 8'hFF);
        send_command(OP_RESTART, 8'h00, 8'h00);
        send_command(OP_PUSH, 8'h00, 8'h00);
        send_command(OP_PUSH, 8'h00, 8'h00);
        send_command(OP_DECODE, 8'h00, 8'h80);
        send_command(OP_DECODE, 8'h00, 8'h00);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 120)
                no_idle = 1'b1;
            if (n == 140)
                hold_request = 1'b1;
            if (n == 200)
                no_idle = 1'b0;
            if (decoder_sb.fill < MIN_FILL)
                push_pct = 80;
            else if (decoder_sb.fill > 48)
                push_pct = 12;
            else
                push_pct = 40;
            r = $urandom_range(0, 99);
            if (r < 2)
                op = OP_RESTART;
            else if (r < 4)
                op = OP_UNUSED;
            else if ($urandom_range(0, 99) < push_pct)
                op = OP_PUSH;
            else
                op = OP_DECODE;
            send_command(op, 8'($urandom_range(0, 255)), pick_probability());
        end
        cmd_bus.valid <= 1'b0;

        while (decoder_sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (decoder_sb.errors == 0)
            $display("boolean_entropy_decoder_top test passed");
        else
            $display("boolean_entropy_decoder_top test failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/bed_pkg.sv
rtl/bed_if.sv
rtl/boolean_entropy_decoder_top.sv
rtl/bed_checker.sv
tb/testbench.sv
